// File: hdl/rthsv_pkg.sv
// ----------------------------------------------------------------------------
// rthsv_pkg
// Shared types and constants for the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
package rthsv_pkg;

    localparam int ChanW   = 8;
    localparam int QuoW    = 8;                  // quotient bits, one per divider stage
    localparam int HueNumW = 17;                 // up to 360*255
    localparam int HueDivW = 9;                  // 2*delta
    localparam int SatNumW = 16;                 // up to 255*255
    localparam int SatDivW = 8;                  // max channel
    localparam int FifoDepth = 2;

    typedef struct packed {
        logic [HueNumW-1:0] hue_num;
        logic [HueDivW-1:0] hue_div;
        logic [SatNumW-1:0] sat_num;
        logic [SatDivW-1:0] sat_div;
        logic [ChanW-1:0]   brightness;
    } job_t;

endpackage

// File: hdl/rthsv_front.sv
// ----------------------------------------------------------------------------
// rthsv_front
// Finds max/min, picks the hue sector and forms the two division jobs.
// ----------------------------------------------------------------------------
module rthsv_front import rthsv_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [ChanW-1:0] red,
    input  logic [ChanW-1:0] green,
    input  logic [ChanW-1:0] blue,
    output logic             job_valid,
    input  logic             job_ready,
    output job_t             job
);

    logic valid_reg;
    job_t job_reg;
    job_t job_next;

    logic [ChanW-1:0] mx, mn, dl;
    logic [17:0]      n;

    always_comb begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        dl = mx - mn;
        // unsigned modular math; the final value always fits HueNumW bits
        if (mx == red) begin
            if (green >= blue) begin
                n = 18'(green - blue) * 18'd60;
            end else begin
                n = 18'(dl) * 18'd360 - 18'(blue - green) * 18'd60;
            end
        end else if (mx == green) begin
            n = 18'(dl) * 18'd120 + 18'(blue) * 18'd60 - 18'(red) * 18'd60;
        end else begin
            n = 18'(dl) * 18'd240 + 18'(red) * 18'd60 - 18'(green) * 18'd60;
        end
        job_next.brightness = mx;
        if (dl == '0) begin
            job_next.hue_num = '0;
            job_next.hue_div = HueDivW'(1);
        end else begin
            job_next.hue_num = n[HueNumW-1:0];
            job_next.hue_div = {dl, 1'b0};
        end
        job_next.sat_num = SatNumW'(dl) * SatNumW'(255);
        job_next.sat_div = (mx == '0) ? SatDivW'(1) : mx;
    end

    assign in_ready  = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            job_reg <= job_next;
        end
    end

endmodule

// File: hdl/rthsv_fifo.sv
// ----------------------------------------------------------------------------
// rthsv_fifo
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module rthsv_fifo import rthsv_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_pop,
    output job_t rd_data
);

    localparam int PtrW = $clog2(FifoDepth);
    localparam int CntW = $clog2(FifoDepth + 1);

    job_t            mem [FifoDepth];
    logic [PtrW-1:0] wptr_reg, rptr_reg;
    logic [CntW-1:0] count_reg;
    logic            push, pop;

    assign wr_ready = count_reg != CntW'(FifoDepth);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) wptr_reg <= (wptr_reg == PtrW'(FifoDepth - 1)) ? '0 : wptr_reg + 1'b1;
            if (pop)  rptr_reg <= (rptr_reg == PtrW'(FifoDepth - 1)) ? '0 : rptr_reg + 1'b1;
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
        if (push) mem[wptr_reg] <= wr_data;
    end

endmodule

// File: hdl/rthsv_back.sv
// ----------------------------------------------------------------------------
// rthsv_back
// Two pipelined restoring dividers, one quotient bit per stage, with a
// stall chain so bubbles collapse. The last stage is the output register.
// ----------------------------------------------------------------------------
module rthsv_back import rthsv_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             job_valid,
    output logic             job_pop,
    input  job_t             job,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [ChanW-1:0] hue_half,
    output logic [ChanW-1:0] saturation,
    output logic [ChanW-1:0] brightness
);

    logic [QuoW-1:0]    v_reg;
    logic [QuoW-1:0]    move, load;
    logic [HueNumW-1:0] hrem_reg [QuoW];
    logic [HueDivW-1:0] hdiv_reg [QuoW];
    logic [QuoW-1:0]    hq_reg   [QuoW];
    logic [SatNumW-1:0] srem_reg [QuoW];
    logic [SatDivW-1:0] sdiv_reg [QuoW];
    logic [QuoW-1:0]    sq_reg   [QuoW];
    logic [ChanW-1:0]   bri_reg  [QuoW];

    always_comb begin
        move[QuoW-1] = v_reg[QuoW-1] && out_ready;
        load[QuoW-1] = !v_reg[QuoW-1] || move[QuoW-1];
        for (int k = QuoW - 2; k >= 0; k--) begin
            move[k] = v_reg[k] && load[k+1];
            load[k] = !v_reg[k] || move[k];
        end
    end

    assign job_pop = load[0] && job_valid;

    for (genvar k = 0; k < QuoW; k++) begin : g_stage
        logic               src_v;
        logic [HueNumW-1:0] hrem_in, ht;
        logic [HueDivW-1:0] hdiv_in;
        logic [QuoW-1:0]    hq_in;
        logic [SatNumW-1:0] srem_in, st;
        logic [SatDivW-1:0] sdiv_in;
        logic [QuoW-1:0]    sq_in;
        logic [ChanW-1:0]   bri_in;

        if (k == 0) begin : g_first
            assign src_v   = job_valid;
            assign hrem_in = job.hue_num;
            assign hdiv_in = job.hue_div;
            assign hq_in   = '0;
            assign srem_in = job.sat_num;
            assign sdiv_in = job.sat_div;
            assign sq_in   = '0;
            assign bri_in  = job.brightness;
        end else begin : g_next
            assign src_v   = v_reg[k-1];
            assign hrem_in = hrem_reg[k-1];
            assign hdiv_in = hdiv_reg[k-1];
            assign hq_in   = hq_reg[k-1];
            assign srem_in = srem_reg[k-1];
            assign sdiv_in = sdiv_reg[k-1];
            assign sq_in   = sq_reg[k-1];
            assign bri_in  = bri_reg[k-1];
        end

        // trial subtrahend for quotient bit QuoW-1-k
        assign ht = HueNumW'(hdiv_in) << (QuoW - 1 - k);
        assign st = SatNumW'(sdiv_in) << (QuoW - 1 - k);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (load[k]) begin
                v_reg[k] <= src_v;
            end
            if (load[k] && src_v) begin
                hdiv_reg[k] <= hdiv_in;
                sdiv_reg[k] <= sdiv_in;
                bri_reg[k]  <= bri_in;
                if (hrem_in >= ht) begin
                    hrem_reg[k] <= hrem_in - ht;
                    hq_reg[k]   <= hq_in | (QuoW'(1) << (QuoW - 1 - k));
                end else begin
                    hrem_reg[k] <= hrem_in;
                    hq_reg[k]   <= hq_in;
                end
                if (srem_in >= st) begin
                    srem_reg[k] <= srem_in - st;
                    sq_reg[k]   <= sq_in | (QuoW'(1) << (QuoW - 1 - k));
                end else begin
                    srem_reg[k] <= srem_in;
                    sq_reg[k]   <= sq_in;
                end
            end
        end
    end

    assign out_valid  = v_reg[QuoW-1];
    assign hue_half   = hq_reg[QuoW-1];
    assign saturation = sq_reg[QuoW-1];
    assign brightness = bri_reg[QuoW-1];

endmodule

// File: hdl/rgb_to_hsv_pixel.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// 8-bit RGB to HSV converter, hue in half degrees (0..179).
// ----------------------------------------------------------------------------
// Input beats on s_axis carry one pixel: red, green, blue from the low byte.
// Output beats on m_axis carry hue_half, saturation, brightness, low first.
// Saturation = floor(255*(max-min)/max); hue is floored exactly, no rounding.
// Throughput: one pixel per clock, sustained while m_axis_tready is high.
// Path: the front register, the job queue, then the 8-stage divider
// pipeline with one quotient bit per stage, whose last stage is the
// output register.
// When the receiver stalls, beats pile into the divider stages and the
// two-entry queue, then the front register, and only then does
// s_axis_tready drop. Empty stages close up, so no bubbles stay behind.
// Reset (aresetn low, synchronous) empties every stage and the queue;
// no pixel data is kept across reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel import rthsv_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // hue_half[7:0], saturation[15:8], brightness[23:16]
);

    job_t front_job, queue_job;
    logic front_valid, queue_ready, queue_valid, queue_pop;

    rthsv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .red       (s_axis_tdata[7:0]),
        .green     (s_axis_tdata[15:8]),
        .blue      (s_axis_tdata[23:16]),
        .job_valid (front_valid),
        .job_ready (queue_ready),
        .job       (front_job)
    );

    rthsv_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (queue_ready),
        .wr_data  (front_job),
        .rd_valid (queue_valid),
        .rd_pop   (queue_pop),
        .rd_data  (queue_job)
    );

    rthsv_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (queue_valid),
        .job_pop    (queue_pop),
        .job        (queue_job),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .hue_half   (m_axis_tdata[7:0]),
        .saturation (m_axis_tdata[15:8]),
        .brightness (m_axis_tdata[23:16])
    );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the RGB to HSV pixel converter.
// Pixels go in from a queue through a clocked driver with random gaps; a
// clocked monitor with random stalls compares each output beat against an
// in-line computation of hue, saturation and brightness.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic [7:0] brightness;
        logic [7:0] saturation;
        logic [7:0] hue_half;
    } hsv_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    pixel_t pixel_q[$];
    hsv_t   hsv_expected_q[$];
    int     err_cnt = 0;
    int     cycle_cnt = 0;
    int     send_gap = 0;
    int     stall_gap = 0;
    bit     stim_done = 1'b0;

    rgb_to_hsv_pixel u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // red[7:0], green[15:8], blue[23:16]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // hue_half[7:0], saturation[15:8], brightness[23:16]
    );

    always #6 aclk = ~aclk;

    function automatic hsv_t rgb_to_hsv(pixel_t p);
        int   r, g, b, mx, mn, delta, num;
        hsv_t h;
        r = p.red; g = p.green; b = p.blue;
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        delta = mx - mn;
        h.hue_half = 8'd0;
        if (delta != 0) begin
            if (mx == r) begin
                num = 60 * (g - b);
                if (num < 0) num += 360 * delta;
            end else if (mx == g) begin
                num = 60 * (b - r) + 120 * delta;
            end else begin
                num = 60 * (r - g) + 240 * delta;
            end
            h.hue_half = 8'(num / (2 * delta));
        end
        h.saturation = (mx != 0) ? 8'((255 * delta) / mx) : 8'd0;
        h.brightness = 8'(mx);
        return h;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int rand_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, int got, int exp_val);
        $display("mismatch %s: got %0d expected %0d", what, got, exp_val);
        err_cnt++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                hsv_expected_q = {hsv_expected_q, rgb_to_hsv(pixel_t'(s_axis_tdata))};
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    s_axis_tdata  <= pixel_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    send_gap <= (($urandom_range(0, 9) < 3) ? rand_gap() : 0);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        hsv_t got, want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = hsv_t'(m_axis_tdata);
                if (hsv_expected_q.size() == 0) begin
                    report_mismatch("unexpected beat", int'(got), 0);
                end else begin
                    want = hsv_expected_q.pop_front();
                    if (got.hue_half !== want.hue_half)
                        report_mismatch("hue_half", int'(got.hue_half),
                                        int'(want.hue_half));
                    if (got.saturation !== want.saturation)
                        report_mismatch("saturation", int'(got.saturation),
                                        int'(want.saturation));
                    if (got.brightness !== want.brightness)
                        report_mismatch("brightness", int'(got.brightness),
                                        int'(want.brightness));
                end
            end
            if (stall_gap > 0) begin
                stall_gap <= stall_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 9) < 2) stall_gap <= rand_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000) begin
            $display("** rgb_to_hsv_pixel: FAILED **");
            $finish;
        end
    end

    task automatic push_pixel(int r, int g, int b);
        pixel_t p;
        p.red = 8'(r); p.green = 8'(g); p.blue = 8'(b);
        pixel_q = {pixel_q, p};
    endtask

    initial begin
        int sel, base;
        // black, white, greys, primaries, ties, sector edges
        push_pixel(0, 0, 0);
        push_pixel(255, 255, 255);
        push_pixel(128, 128, 128);
        push_pixel(255, 0, 0);
        push_pixel(0, 255, 0);
        push_pixel(0, 0, 255);
        push_pixel(255, 255, 0);
        push_pixel(0, 255, 255);
        push_pixel(255, 0, 255);
        push_pixel(255, 0, 1);
        push_pixel(255, 1, 0);
        push_pixel(1, 255, 0);
        push_pixel(0, 255, 1);
        push_pixel(1, 0, 255);
        push_pixel(0, 1, 255);
        push_pixel(1, 0, 0);
        push_pixel(200, 200, 100);
        push_pixel(100, 200, 200);
        push_pixel(200, 100, 200);
        push_pixel(254, 255, 253);
        push_pixel(170, 85, 85);
        for (int i = 0; i < 1200; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                push_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255));
            end else if (sel < 8) begin
                // near-grey: small deltas stress the divider
                base = $urandom_range(0, 255);
                push_pixel(base ^ $urandom_range(0, 3), base ^ $urandom_range(0, 3),
                           base ^ $urandom_range(0, 3));
            end else begin
                // ties on the maximum
                base = $urandom_range(0, 255);
                case ($urandom_range(0, 2))
                    0: push_pixel(base, base, $urandom_range(0, base));
                    1: push_pixel($urandom_range(0, base), base, base);
                    default: push_pixel(base, $urandom_range(0, base), base);
                endcase
            end
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pixel_q.size() == 0 && !s_axis_tvalid);
        wait (hsv_expected_q.size() == 0);
        repeat (30) @(posedge aclk);
        if (err_cnt == 0 && hsv_expected_q.size() == 0) begin
            $display("** rgb_to_hsv_pixel: PASSED **");
        end else begin
            $display("** rgb_to_hsv_pixel: FAILED **");
        end
        $finish;
    end

endmodule
